// File: rtl/core/cholesky_factor_with_retry_defines.svh
// ============================================================================
// cholesky_factor_with_retry_defines
// Assertion macros used by the checker of the factor block
// ============================================================================
`ifndef CHOLESKY_FACTOR_WITH_RETRY_DEFINES_SVH
`define CHOLESKY_FACTOR_WITH_RETRY_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define CFR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define CFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: rtl/core/cfr_pkg.sv
// ============================================================================
// cfr_pkg
// Constants, command and status types and saturating helpers for the factor block
// ============================================================================
package cfr_pkg;

    // sizes
    localparam int MAX_VARS    = 8;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_RETRIES = 10;
    localparam int IDX_W       = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int DEPTH       = 1 << ADDR_W;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 64;
    localparam int DIM_W       = 4;
    localparam int RET_W       = 4;
    localparam int REM_W       = 36;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 64;
    localparam int STEP_W      = 6;

    // register map
    localparam logic REG_VARS_IN_USE = 1'b0;

    // controller to datapath
    typedef struct packed {
        logic              load_wr;
        logic [ADDR_W-1:0] load_addr;
        logic              mat_rd;
        logic              half_wr;
        logic [ADDR_W-1:0] mat_addr;
        logic              fac_rd;
        logic [ADDR_W-1:0] fa_addr;
        logic [ADDR_W-1:0] fb_addr;
        logic              acc_clr;
        logic              mul;
        logic              acc_add;
        logic              diff;
        logic              sqrt_start;
        logic              sqrt_step;
        logic              div_start;
        logic              div_step;
        logic              fac_wr;
        logic              res_sqrt;
        logic [ADDR_W-1:0] fac_waddr;
        logic              emit;
        logic              emit_err;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
        logic [RET_W-1:0]  retries;
    } cfr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic diff_neg;
        logic piv_bad;
    } cfr_status_t;

    // signed add, clamped to the 64-bit range
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W-1:0] s;
        s = a + b;
        if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]))
            s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s;
    endfunction

    // signed subtract, clamped to the 64-bit range
    function automatic logic [ACC_W-1:0] sat_sub(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W-1:0] s;
        s = a - b;
        if ((a[ACC_W-1] != b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]))
            s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s;
    endfunction

endpackage

// File: rtl/core/cfr_datapath.sv
// ============================================================================
// cfr_datapath
// Matrix and factor stores, multiply-accumulate, shared root/divide unit
// and result registers
// ============================================================================
module cfr_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfr_pkg::cfr_cmd_t             cmd,
    input  logic [cfr_pkg::DATA_W-1:0]    entry_value,
    output cfr_pkg::cfr_status_t          status,
    output logic                          result_valid,
    output logic [cfr_pkg::DATA_W-1:0]    factor_value,
    output logic [cfr_pkg::IDX_W-1:0]     row_index,
    output logic [cfr_pkg::IDX_W-1:0]     column_index,
    output logic                          last_of_run,
    output logic [cfr_pkg::RET_W-1:0]     retries_used,
    output logic                          failed
);

    localparam int DW = cfr_pkg::DATA_W;
    localparam int AW = cfr_pkg::ACC_W;
    localparam int RW = cfr_pkg::REM_W;

    logic [DW-1:0] mat_mem [cfr_pkg::DEPTH];
    logic [DW-1:0] fac_mem [cfr_pkg::DEPTH];

    logic [DW-1:0] mat_rdata_reg;
    logic [DW-1:0] fa_rdata_reg;
    logic [DW-1:0] fb_rdata_reg;
    logic [AW-1:0] prod_reg;
    logic [AW-1:0] acc_reg;
    logic [AW-1:0] diff_reg;
    logic [AW-1:0] val_reg;
    logic [RW-1:0] rem_reg;
    logic [DW-1:0] root_reg;
    logic [DW-1:0] piv_reg;
    logic          neg_reg;

    logic          valid_reg;
    logic [DW-1:0] value_reg;
    logic [cfr_pkg::IDX_W-1:0] row_reg;
    logic [cfr_pkg::IDX_W-1:0] col_reg;
    logic          last_reg;
    logic [cfr_pkg::RET_W-1:0] ret_reg;
    logic          fail_reg;

    logic [AW-1:0] mat_scaled;
    logic [AW-1:0] diff_mag;
    logic [RW-1:0] sq_shift;
    logic [RW-1:0] sq_trial;
    logic [RW-1:0] dv_shift;
    logic [RW-1:0] dv_piv;
    logic [DW-1:0] root_sat;
    logic [DW-1:0] quot_sat;
    logic [DW-1:0] fac_wdata;

    // matrix store: load and halving writes, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
            mat_mem[cmd.load_addr] <= entry_value;
        else if (cmd.half_wr)
            mat_mem[cmd.mat_addr] <= {mat_rdata_reg[DW-1], mat_rdata_reg[DW-1:1]};
        if (cmd.mat_rd)
            mat_rdata_reg <= mat_mem[cmd.mat_addr];
    end

    // factor store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.fac_wr)
            fac_mem[cmd.fac_waddr] <= fac_wdata;
        if (cmd.fac_rd)
        begin
            fa_rdata_reg <= fac_mem[cmd.fa_addr];
            fb_rdata_reg <= fac_mem[cmd.fb_addr];
        end
    end

    // scaled entry and magnitude of the difference
    assign mat_scaled = {{(AW-DW){mat_rdata_reg[DW-1]}}, mat_rdata_reg} << cfr_pkg::FRAC_BITS;
    assign diff_mag   = diff_reg[AW-1] ? (~diff_reg + AW'(1)) : diff_reg;

    // one root digit: bring in two bits, try 4*root+1
    assign sq_shift = {rem_reg[RW-3:0], val_reg[AW-1 -: 2]};
    assign sq_trial = {{(RW-DW-2){1'b0}}, root_reg, 2'b01};

    // one quotient bit: bring in one bit, try the pivot
    assign dv_shift = {rem_reg[RW-2:0], val_reg[AW-1]};
    assign dv_piv   = {{(RW-DW){1'b0}}, piv_reg};

    // clamp root and quotient to the 32-bit range
    assign root_sat = root_reg[DW-1] ? {1'b0, {(DW-1){1'b1}}} : root_reg;

    always_comb
    begin
        if (neg_reg)
        begin
            if (val_reg > {{(AW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}})
                quot_sat = {1'b1, {(DW-1){1'b0}}};
            else
                quot_sat = ~val_reg[DW-1:0] + DW'(1);
        end
        else
        begin
            if (val_reg > {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}})
                quot_sat = {1'b0, {(DW-1){1'b1}}};
            else
                quot_sat = val_reg[DW-1:0];
        end
    end

    assign fac_wdata = cmd.res_sqrt ? root_sat : quot_sat;

    // multiply, accumulate, difference
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= AW'($signed(fa_rdata_reg) * $signed(fb_rdata_reg));
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc_add)
            acc_reg <= cfr_pkg::sat_add(acc_reg, prod_reg);
        if (cmd.diff)
            diff_reg <= cfr_pkg::sat_sub(mat_scaled, acc_reg);
    end

    // shared digit-serial root and divide unit
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            val_reg  <= diff_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            val_reg <= diff_mag;
            rem_reg <= '0;
            piv_reg <= fb_rdata_reg;
            neg_reg <= diff_reg[AW-1];
        end
        else if (cmd.sqrt_step)
        begin
            val_reg <= {val_reg[AW-3:0], 2'b00};
            if (sq_shift >= sq_trial)
            begin
                rem_reg  <= sq_shift - sq_trial;
                root_reg <= {root_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= sq_shift;
                root_reg <= {root_reg[DW-2:0], 1'b0};
            end
        end
        else if (cmd.div_step)
        begin
            if (dv_shift >= dv_piv)
            begin
                rem_reg <= dv_shift - dv_piv;
                val_reg <= {val_reg[AW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= dv_shift;
                val_reg <= {val_reg[AW-2:0], 1'b0};
            end
        end
    end

    // failure tests
    assign status.diff_neg = diff_reg[AW-1];
    assign status.piv_bad  = fb_rdata_reg[DW-1] || (fb_rdata_reg == '0);

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.emit || cmd.emit_err;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit || cmd.emit_err)
        begin
            value_reg <= cmd.emit_err ? '0 : fa_rdata_reg;
            row_reg   <= cmd.row;
            col_reg   <= cmd.col;
            last_reg  <= cmd.last;
            ret_reg   <= cmd.retries;
            fail_reg  <= cmd.emit_err;
        end
    end

    assign result_valid = valid_reg;
    assign factor_value = value_reg;
    assign row_index    = row_reg;
    assign column_index = col_reg;
    assign last_of_run  = last_reg;
    assign retries_used = ret_reg;
    assign failed       = fail_reg;

endmodule

// File: rtl/core/cfr_ctrl.sv
// ============================================================================
// cfr_ctrl
// Sequencer for load, factor, halving retry and result output
// ============================================================================
module cfr_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          cfg_wr,
    input  logic [cfr_pkg::DIM_W-1:0]     vars,
    input  cfr_pkg::cfr_status_t          status,
    output logic                          busy,
    output cfr_pkg::cfr_cmd_t             cmd
);

    localparam int IW = cfr_pkg::IDX_W;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_ELEM  = 15'b000000000000010,
        S_MRD   = 15'b000000000000100,
        S_MUL   = 15'b000000000001000,
        S_ACC   = 15'b000000000010000,
        S_DIFF  = 15'b000000000100000,
        S_CHECK = 15'b000000001000000,
        S_SQRT  = 15'b000000010000000,
        S_DIV   = 15'b000000100000000,
        S_WRITE = 15'b000001000000000,
        S_HRD   = 15'b000010000000000,
        S_HWR   = 15'b000100000000000,
        S_ORD   = 15'b001000000000000,
        S_EMIT  = 15'b010000000000000,
        S_ERR   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0] lrow_reg, lrow_next;
    logic [IW-1:0] lcol_reg, lcol_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [cfr_pkg::STEP_W-1:0] step_reg, step_next;
    logic [cfr_pkg::RET_W-1:0]  fails_reg, fails_next;

    logic [cfr_pkg::DIM_W-1:0] dim_n;
    logic [cfr_pkg::DIM_W-1:0] dim_m1;
    logic [IW-1:0] last_idx;
    logic          fails_done;

    // clamp the dimension to 1..MAX_VARS
    always_comb
    begin
        if (vars == '0)
            dim_n = cfr_pkg::DIM_W'(1);
        else if ({1'b0, vars} > (cfr_pkg::DIM_W+1)'(cfr_pkg::MAX_VARS))
            dim_n = cfr_pkg::DIM_W'(cfr_pkg::MAX_VARS);
        else
            dim_n = vars;
    end

    assign dim_m1     = dim_n - cfr_pkg::DIM_W'(1);
    assign last_idx   = dim_m1[IW-1:0];
    assign fails_done = (fails_reg + cfr_pkg::RET_W'(1)) == cfr_pkg::RET_W'(cfr_pkg::MAX_RETRIES);
    assign busy       = (state_reg != S_IDLE);

    // state and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lrow_reg  <= '0;
            lcol_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            step_reg  <= '0;
            fails_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lrow_reg  <= lrow_next;
            lcol_reg  <= lcol_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
            fails_reg <= fails_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        lrow_next  = lrow_reg;
        lcol_next  = lcol_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        fails_next = fails_reg;

        cmd           = '0;
        cmd.load_addr = {lrow_reg, lcol_reg};
        cmd.mat_addr  = {i_reg, j_reg};
        cmd.fa_addr   = {i_reg, k_reg};
        cmd.fb_addr   = {j_reg, k_reg};
        cmd.fac_waddr = {i_reg, j_reg};
        cmd.res_sqrt  = (i_reg == j_reg);
        cmd.row       = i_reg;
        cmd.col       = j_reg;
        cmd.last      = (i_reg == last_idx) && (j_reg == i_reg);
        cmd.retries   = fails_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_wr)
                begin
                    lrow_next = '0;
                    lcol_next = '0;
                end
                else if (start)
                begin
                    cmd.load_wr = 1'b1;
                    if (lcol_reg == last_idx)
                    begin
                        lcol_next = '0;
                        if (lrow_reg == last_idx)
                        begin
                            lrow_next  = '0;
                            i_next     = '0;
                            j_next     = '0;
                            fails_next = '0;
                            state_next = S_ELEM;
                        end
                        else
                            lrow_next = lrow_reg + IW'(1);
                    end
                    else
                        lcol_next = lcol_reg + IW'(1);
                end
            end

            // start an element: fetch its matrix entry
            S_ELEM:
            begin
                cmd.mat_rd  = 1'b1;
                cmd.acc_clr = 1'b1;
                k_next      = '0;
                state_next  = (j_reg == '0) ? S_DIFF : S_MRD;
            end

            S_MRD:
            begin
                cmd.fac_rd = 1'b1;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end

            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                if (k_reg == j_reg - IW'(1))
                    state_next = S_DIFF;
                else
                begin
                    k_next     = k_reg + IW'(1);
                    state_next = S_MRD;
                end
            end

            // difference, and fetch the pivot
            S_DIFF:
            begin
                cmd.diff    = 1'b1;
                cmd.fac_rd  = 1'b1;
                cmd.fa_addr = {j_reg, j_reg};
                cmd.fb_addr = {j_reg, j_reg};
                state_next  = S_CHECK;
            end

            S_CHECK:
            begin
                step_next = '0;
                if ((i_reg == j_reg) ? status.diff_neg : status.piv_bad)
                begin
                    fails_next = fails_reg + cfr_pkg::RET_W'(1);
                    i_next     = '0;
                    j_next     = '0;
                    state_next = fails_done ? S_ERR : S_HRD;
                end
                else if (i_reg == j_reg)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end

            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + cfr_pkg::STEP_W'(1);
                if (step_reg == cfr_pkg::STEP_W'(cfr_pkg::SQRT_STEPS - 1))
                    state_next = S_WRITE;
            end

            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + cfr_pkg::STEP_W'(1);
                if (step_reg == cfr_pkg::STEP_W'(cfr_pkg::DIV_STEPS - 1))
                    state_next = S_WRITE;
            end

            // store the entry, walk the lower triangle
            S_WRITE:
            begin
                cmd.fac_wr = 1'b1;
                if (j_reg == i_reg)
                begin
                    j_next = '0;
                    if (i_reg == last_idx)
                    begin
                        i_next     = '0;
                        state_next = S_ORD;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_ELEM;
                    end
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_ELEM;
                end
            end

            // halving pass over the whole matrix
            S_HRD:
            begin
                cmd.mat_rd = 1'b1;
                state_next = S_HWR;
            end

            S_HWR:
            begin
                cmd.half_wr = (i_reg != j_reg);
                state_next  = S_HRD;
                if (j_reg == last_idx)
                begin
                    j_next = '0;
                    if (i_reg == last_idx)
                    begin
                        i_next     = '0;
                        state_next = S_ELEM;
                    end
                    else
                        i_next = i_reg + IW'(1);
                end
                else
                    j_next = j_reg + IW'(1);
            end

            // output pass, row by row
            S_ORD:
            begin
                cmd.fac_rd  = 1'b1;
                cmd.fa_addr = {i_reg, j_reg};
                state_next  = S_EMIT;
            end

            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_ORD;
                if (j_reg == i_reg)
                begin
                    j_next = '0;
                    if (i_reg == last_idx)
                    begin
                        i_next     = '0;
                        state_next = S_IDLE;
                    end
                    else
                        i_next = i_reg + IW'(1);
                end
                else
                    j_next = j_reg + IW'(1);
            end

            S_ERR:
            begin
                cmd.emit_err = 1'b1;
                cmd.row      = '0;
                cmd.col      = '0;
                cmd.last     = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/cholesky_factor_with_retry.sv
// ============================================================================
// cholesky_factor_with_retry
// Fixed-point Cholesky factor of a loaded symmetric matrix, retried with
// halved off-diagonal entries on failure
// ============================================================================
//
//  channel   handshake                 payload
//  -------   ---------                 -------
//  config    psel/penable/pwrite/pready vars_in_use at paddr 0
//  input     start & !busy             entry_value
//  result    result_valid (one cycle)  factor_value, row_index, column_index,
//                                      last_of_run, retries_used, failed
//
//  loading takes one item per cycle while start is high and no config write comes;
//  busy stays low until the last of n*n items
//  an attempt works each lower-triangle entry from its product terms, then takes
//  a diagonal root or a divide; a failed attempt adds a halving pass before the next one
//  results come out one at a time, each after a read of the factor store read port
//  reset clears the controller and the load position; the stores need no clear
//
module cholesky_factor_with_retry
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic [cfr_pkg::DATA_W-1:0]    entry_value,
    output logic                          result_valid,
    output logic [cfr_pkg::DATA_W-1:0]    factor_value,
    output logic [cfr_pkg::IDX_W-1:0]     row_index,
    output logic [cfr_pkg::IDX_W-1:0]     column_index,
    output logic                          last_of_run,
    output logic [cfr_pkg::RET_W-1:0]     retries_used,
    output logic                          failed
);

    logic [cfr_pkg::DIM_W-1:0] vars_reg;
    logic                      cfg_wr;
    cfr_pkg::cfr_cmd_t         cmd;
    cfr_pkg::cfr_status_t      status;

    // register write decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cfr_pkg::REG_VARS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vars_reg <= cfr_pkg::DIM_W'(cfr_pkg::MAX_VARS);
        else if (cfg_wr)
            vars_reg <= pwdata[cfr_pkg::DIM_W-1:0];
    end

    // register read
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == cfr_pkg::REG_VARS_IN_USE)
            prdata = {{(32-cfr_pkg::DIM_W){1'b0}}, vars_reg};
    end

    cfr_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_wr (cfg_wr),
        .vars   (vars_reg),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    cfr_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .entry_value  (entry_value),
        .status       (status),
        .result_valid (result_valid),
        .factor_value (factor_value),
        .row_index    (row_index),
        .column_index (column_index),
        .last_of_run  (last_of_run),
        .retries_used (retries_used),
        .failed       (failed)
    );

endmodule

// File: rtl/core/cfr_checker.sv
// ============================================================================
// cfr_checker
// Port-level checks on the result stream of the factor block
// ============================================================================
`include "cholesky_factor_with_retry_defines.svh"

module cfr_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          result_valid,
    input logic [cfr_pkg::DATA_W-1:0]    factor_value,
    input logic [cfr_pkg::IDX_W-1:0]     row_index,
    input logic [cfr_pkg::IDX_W-1:0]     column_index,
    input logic                          last_of_run,
    input logic [cfr_pkg::RET_W-1:0]     retries_used,
    input logic                          failed
);

    logic err_shape;

    // shape of the error item: zero, at the origin, last, all retries spent
    assign err_shape = (factor_value == '0) && last_of_run && (row_index == '0) &&
                       (column_index == '0) &&
                       (retries_used == cfr_pkg::RET_W'(cfr_pkg::MAX_RETRIES));

    // the error item has the fixed shape
    `CFR_ASSERT_IMPL(a_err_item, result_valid && failed, err_shape)

    // only the lower triangle comes out
    `CFR_ASSERT_IMPL(a_lower, result_valid, column_index <= row_index)

    // a good run used fewer halvings than the limit
    `CFR_ASSERT_IMPL(a_retry_bound, result_valid && !failed, retries_used < cfr_pkg::RET_W'(cfr_pkg::MAX_RETRIES))

    // work only begins on an accepted item
    `CFR_ASSERT_IMPL(a_busy_cause, $rose(busy), $past(start))

    // no result directly follows the last item of a run
    `CFR_ASSERT_NEXT(a_run_end, result_valid && last_of_run, !result_valid)

endmodule

bind cholesky_factor_with_retry cfr_checker u_cfr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .factor_value (factor_value),
    .row_index    (row_index),
    .column_index (column_index),
    .last_of_run  (last_of_run),
    .retries_used (retries_used),
    .failed       (failed)
);
